// ===== hw/rtl/tpsg_pkg.sv =====
// Shared types, constants and helper functions for the TMDS palette symbol pair generator.
// No dependencies; used by tpsg_chan_enc and tmds_palette_symbol_pair_gen.
package tpsg_pkg;

   localparam int PALETTE_ENTRIES = 256;          // palette depth, 2 to 256

   localparam logic [9:0] SYM_INV_MASK = 10'h2FF; // invert data bits, set bit 9

   localparam logic COLOR_FMT_RGB565 = 1'b0;
   localparam logic COLOR_FMT_RGB888 = 1'b1;

   typedef struct packed {
      logic [23:0] palette_color;
      logic [7:0]  entry_index;
      logic        last_entry;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] blue_neg_word;
      logic [31:0] blue_pos_word;
      logic [31:0] green_neg_word;
      logic [31:0] green_pos_word;
      logic [31:0] red_neg_word;
      logic [31:0] red_pos_word;
      logic [7:0]  index_out;
      logic        last_out;
   } rsp_payload_type;

   // per-stage load enables of the pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   function automatic logic [3:0] ones8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   // Wrap an entry number into the palette range by conditional subtraction
   // of the depth scaled by powers of two, largest first.
   function automatic logic [7:0] wrap_index(input logic [7:0] v);
      logic [8:0] r;
      r = {1'b0, v};
      for (int k = 7; k >= 0; k--) begin
         if ((PALETTE_ENTRIES << k) <= 255) begin
            if (r >= 9'(PALETTE_ENTRIES << k)) begin
               r = r - 9'(PALETTE_ENTRIES << k);
            end
         end
      end
      return r[7:0];
   endfunction

endpackage

// ===== hw/rtl/tmds_palette_symbol_pair_gen.sv =====
// Top level of the TMDS palette symbol pair generator.
// Depends on tpsg_pkg and tpsg_chan_enc.
//
// Usage: each transaction on the req_ channel carries one palette color, its
// entry number and a last flag. csr_wr_en/csr_wr_data select the color format
// (0 = RGB565 in bits 15:0, 1 = RGB888); write it only while the block is idle.
// For each color the rsp_ channel returns, per channel, the 32-bit TMDS word for
// negative and for positive running disparity (symbol in bits 9:0, signed
// change in bits 31:26), plus the wrapped entry number and the last flag.
// Pipeline: three register stages (popcount and XNOR decision, q_m chain, word
// build); rsp_valid is the valid flag of the word-build stage. Throughput: one
// transaction per cycle, sustained, while rsp_stall stays low.
// Stall: a stage loads only when it is empty or the stage after it advances, so
// bubbles collapse; req_stall rises only when all three stages hold data and
// rsp_stall is high. The result on rsp_ holds until taken.
// Reset (synchronous, active high): empties the pipeline and sets RGB565 mode.
module tmds_palette_symbol_pair_gen (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tpsg_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tpsg_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data
);

   logic       color_format_ff;
   logic [2:0] valid_ff;
   logic [2:0] valid_in;
   tpsg_pkg::stage_en_type stage_en;

   logic [7:0] blue_byte;
   logic [7:0] green_byte;
   logic [7:0] red_byte;

   logic [7:0] idx1_ff;
   logic [7:0] idx2_ff;
   logic [7:0] idx3_ff;
   logic [2:0] last_ff;

   always_comb begin
      stage_en.s3 = !valid_ff[2] || !rsp_stall;
      stage_en.s2 = !valid_ff[1] || stage_en.s3;
      stage_en.s1 = !valid_ff[0] || stage_en.s2;
      valid_in[0] = stage_en.s1 ? req_valid   : valid_ff[0];
      valid_in[1] = stage_en.s2 ? valid_ff[0] : valid_ff[1];
      valid_in[2] = stage_en.s3 ? valid_ff[1] : valid_ff[2];
   end

   assign req_stall = !stage_en.s1;
   assign rsp_valid = valid_ff[2];

   always_comb begin
      unique case (color_format_ff)
         tpsg_pkg::COLOR_FMT_RGB888: begin
            blue_byte  = req_payload.palette_color[7:0];
            green_byte = req_payload.palette_color[15:8];
            red_byte   = req_payload.palette_color[23:16];
         end
         tpsg_pkg::COLOR_FMT_RGB565: begin
            // left-align each field, zero the low bits
            blue_byte  = {req_payload.palette_color[4:0], 3'b000};
            green_byte = {req_payload.palette_color[10:5], 2'b00};
            red_byte   = {req_payload.palette_color[15:11], 3'b000};
         end
         default: begin
            blue_byte  = 8'd0;
            green_byte = 8'd0;
            red_byte   = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_format_ff <= tpsg_pkg::COLOR_FMT_RGB565;
         valid_ff        <= 3'b000;
      end else begin
         if (csr_wr_en) begin
            color_format_ff <= csr_wr_data;
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         idx1_ff    <= tpsg_pkg::wrap_index(req_payload.entry_index);
         last_ff[0] <= req_payload.last_entry;
      end
      if (stage_en.s2) begin
         idx2_ff    <= idx1_ff;
         last_ff[1] <= last_ff[0];
      end
      if (stage_en.s3) begin
         idx3_ff    <= idx2_ff;
         last_ff[2] <= last_ff[1];
      end
   end

   tpsg_chan_enc u_blue (
      .clock     (clock),
      .stage_en  (stage_en),
      .chan_byte (blue_byte),
      .neg_word  (rsp_payload.blue_neg_word),
      .pos_word  (rsp_payload.blue_pos_word)
   );

   tpsg_chan_enc u_green (
      .clock     (clock),
      .stage_en  (stage_en),
      .chan_byte (green_byte),
      .neg_word  (rsp_payload.green_neg_word),
      .pos_word  (rsp_payload.green_pos_word)
   );

   tpsg_chan_enc u_red (
      .clock     (clock),
      .stage_en  (stage_en),
      .chan_byte (red_byte),
      .neg_word  (rsp_payload.red_neg_word),
      .pos_word  (rsp_payload.red_pos_word)
   );

   assign rsp_payload.index_out = idx3_ff;
   assign rsp_payload.last_out  = last_ff[2];

   // accepted transaction lands in stage 1
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted transaction not captured in stage 1");

   // input stalls only with a full pipeline and a stalled receiver
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid_ff == 3'b111) && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // a blocked middle stage keeps its transaction
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && valid_ff[2] && rsp_stall |=> valid_ff[1])
      else $error("stage 2 transaction dropped under stall");

   // stage 2 moves its data forward once stage 3 is empty or its output is taken
   a_s2_advance: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && !(valid_ff[2] && rsp_stall) |=> valid_ff[2])
      else $error("stage 2 transaction did not advance");

endmodule

// ===== hw/rtl/tpsg_chan_enc.sv =====
// Three-stage TMDS transition-minimizing encoder for one color channel; emits both
// candidate words (negative and positive running disparity). Depends on tpsg_pkg.
module tpsg_chan_enc (
   input  logic                 clock,
   input  tpsg_pkg::stage_en_type stage_en,
   input  logic [7:0]           chan_byte,
   output logic [31:0]          neg_word,
   output logic [31:0]          pos_word
);

   // stage 1: byte and the XNOR decision
   logic [7:0] byte_ff;
   logic       xnor_ff;
   logic [3:0] in_ones;
   logic       xnor_in;

   // stage 2: q_m
   logic [8:0] qm_ff;
   logic [8:0] qm_in;

   // stage 3: output words
   logic [31:0] neg_ff;
   logic [31:0] pos_ff;
   logic [31:0] neg_in;
   logic [31:0] pos_in;

   logic [3:0]        qm_ones;
   logic signed [5:0] excess;
   logic signed [5:0] q8x2;
   logic signed [5:0] chg_inv;
   logic signed [5:0] chg_plain;
   logic [9:0]        inv_sym;
   logic [9:0]        plain_sym;
   logic [31:0]       inv_word;
   logic [31:0]       plain_word;
   logic [31:0]       bal_word;

   always_comb begin
      in_ones = tpsg_pkg::ones8(chan_byte);
      xnor_in = (in_ones > 4'd4) || ((in_ones == 4'd4) && !chan_byte[0]);
   end

   always_comb begin
      qm_in[0] = byte_ff[0];
      for (int i = 0; i < 7; i++) begin
         qm_in[i + 1] = qm_in[i] ^ byte_ff[i + 1] ^ xnor_ff;
      end
      qm_in[8] = !xnor_ff;
   end

   always_comb begin
      qm_ones    = tpsg_pkg::ones8(qm_ff[7:0]);
      excess     = $signed({1'b0, qm_ones, 1'b0}) - 6'sd8;
      q8x2       = $signed({4'b0000, qm_ff[8], 1'b0});
      chg_inv    = q8x2 - excess;
      chg_plain  = excess - 6'sd2 + q8x2;
      inv_sym    = {1'b0, qm_ff} ^ tpsg_pkg::SYM_INV_MASK;
      plain_sym  = {1'b0, qm_ff};
      inv_word   = {chg_inv, 16'b0, inv_sym};
      plain_word = {chg_plain, 16'b0, plain_sym};
      bal_word   = {22'b0, (qm_ff[8] ? plain_sym : inv_sym)};
      priority if (excess == 6'sd0) begin
         neg_in = bal_word;
         pos_in = bal_word;
      end else if (!excess[5]) begin
         // more ones than zeros: invert when disparity is positive
         neg_in = plain_word;
         pos_in = inv_word;
      end else begin
         neg_in = inv_word;
         pos_in = plain_word;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         byte_ff <= chan_byte;
         xnor_ff <= xnor_in;
      end
      if (stage_en.s2) begin
         qm_ff <= qm_in;
      end
      if (stage_en.s3) begin
         neg_ff <= neg_in;
         pos_ff <= pos_in;
      end
   end

   assign neg_word = neg_ff;
   assign pos_word = pos_ff;

endmodule
